// File: design/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg - shared types and constants of the SPI master byte shifter
// Word size, half-bit counts, command codes and the queued item format.
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

  localparam int BITS_PER_WORD = 8;
  localparam int HALF_BITS     = 2 * BITS_PER_WORD;
  localparam int HB_W          = $clog2(HALF_BITS);
  localparam int MODE_W        = 2;

  localparam logic [MODE_W-1:0] XFER_MODE_RESET = MODE_W'(1);

  // Field positions in the mode register
  localparam int MODE_CPOL_BIT = 1;
  localparam int MODE_CPHA_BIT = 0;

  // Command codes on the input channel
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t               kind;
    logic [BITS_PER_WORD-1:0] tx_byte;
    logic                     end_frame;
    logic                     miso_level;
  } sms_item_t;

  // Handshake between the front queue and the back engine
  typedef struct packed {
    logic      valid;
    sms_item_t item;
  } sms_queue_out_t;

endpackage : sms_pkg

`default_nettype wire

// File: design/sms_front.sv
// ----------------------------------------------------------------------------
// sms_front - input stage of the SPI master byte shifter
// Accepts items, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_front import sms_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     cmd,
  input  wire logic [BITS_PER_WORD-1:0] tx_byte,
  input  wire logic                     end_frame,
  input  wire logic                     miso_level,
  output sms_queue_out_t                q_out,
  input  wire logic                     q_ready
);

  sms_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  sms_item_t  item_in;

  always_comb begin
    item_in.kind       = (cmd == CMD_LOAD) ? KIND_LOAD : KIND_TICK;
    item_in.tx_byte    = tx_byte;
    item_in.end_frame  = end_frame;
    item_in.miso_level = miso_level;
  end

  assign in_ready    = (count != 2'd2);
  assign push        = in_valid && in_ready;
  assign q_out.valid = (count != 2'd0);
  assign q_out.item  = entries[rd_ptr];
  assign pop         = q_out.valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule : sms_front

`default_nettype wire

// File: design/sms_back.sv
// ----------------------------------------------------------------------------
// sms_back - shift engine of the SPI master byte shifter
// Executes queued loads and ticks, keeps the pin state and the output item.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_back import sms_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire sms_queue_out_t           q_out,
  output logic                          q_ready,
  input  wire logic                     xfer_mode_we,
  input  wire logic [MODE_W-1:0]        xfer_mode_wdata,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          sck_level,
  output logic                          mosi_level,
  output logic                          cs_n,
  output logic                          busy_res,
  output logic                          rx_valid,
  output logic [BITS_PER_WORD-1:0]      rx_byte
);

  logic [MODE_W-1:0]        xfer_mode;
  logic [BITS_PER_WORD-1:0] tx_shift;
  logic [BITS_PER_WORD-1:0] rx_shift;
  logic [HB_W-1:0]          half_bit_count;
  logic                     active;
  logic                     frame_open;
  logic                     close_after;
  logic                     clock_pin;
  logic                     data_pin;

  logic [BITS_PER_WORD-1:0] tx_shift_next;
  logic [BITS_PER_WORD-1:0] rx_shift_next;
  logic [HB_W-1:0]          half_bit_count_next;
  logic                     active_next;
  logic                     frame_open_next;
  logic                     close_after_next;
  logic                     clock_pin_next;
  logic                     data_pin_next;
  logic                     valid_next;

  logic cpol;
  logic cpha;
  logic exec;
  logic last_half;

  assign cpol      = xfer_mode[MODE_CPOL_BIT];
  assign cpha      = xfer_mode[MODE_CPHA_BIT];
  assign q_ready   = !out_valid || out_ready;
  assign exec      = q_out.valid && q_ready;
  assign last_half = (half_bit_count == HB_W'(HALF_BITS - 1));

  always_comb begin
    tx_shift_next       = tx_shift;
    rx_shift_next       = rx_shift;
    half_bit_count_next = half_bit_count;
    active_next         = active;
    frame_open_next     = frame_open;
    close_after_next    = close_after;
    clock_pin_next      = clock_pin;
    data_pin_next       = data_pin;
    valid_next          = 1'b0;
    case (q_out.item.kind)
      KIND_LOAD: begin
        if (!active) begin
          tx_shift_next       = q_out.item.tx_byte;
          rx_shift_next       = '0;
          half_bit_count_next = '0;
          active_next         = 1'b1;
          frame_open_next     = 1'b1;
          close_after_next    = q_out.item.end_frame;
          clock_pin_next      = cpol;
          if (!cpha) begin
            data_pin_next = q_out.item.tx_byte[BITS_PER_WORD-1];
            tx_shift_next = {q_out.item.tx_byte[BITS_PER_WORD-2:0], 1'b0};
          end
        end
      end
      KIND_TICK: begin
        if (active) begin
          if (!half_bit_count[0]) begin
            // leading edge
            clock_pin_next = ~cpol;
            if (!cpha) begin
              rx_shift_next = {rx_shift[BITS_PER_WORD-2:0], q_out.item.miso_level};
            end else begin
              data_pin_next = tx_shift[BITS_PER_WORD-1];
              tx_shift_next = {tx_shift[BITS_PER_WORD-2:0], 1'b0};
            end
          end else begin
            // trailing edge
            clock_pin_next = cpol;
            if (!cpha) begin
              if (!last_half) begin
                data_pin_next = tx_shift[BITS_PER_WORD-1];
                tx_shift_next = {tx_shift[BITS_PER_WORD-2:0], 1'b0};
              end
            end else begin
              rx_shift_next = {rx_shift[BITS_PER_WORD-2:0], q_out.item.miso_level};
            end
          end
          half_bit_count_next = half_bit_count + HB_W'(1);
          if (last_half) begin
            half_bit_count_next = '0;
            active_next         = 1'b0;
            valid_next          = 1'b1;
            if (close_after) begin
              frame_open_next  = 1'b0;
              close_after_next = 1'b0;
            end
          end
        end
      end
      default: begin
        valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_mode      <= XFER_MODE_RESET;
      tx_shift       <= '0;
      rx_shift       <= '0;
      half_bit_count <= '0;
      active         <= 1'b0;
      frame_open     <= 1'b0;
      close_after    <= 1'b0;
      clock_pin      <= 1'b0;
      data_pin       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (exec) begin
        tx_shift       <= tx_shift_next;
        rx_shift       <= rx_shift_next;
        half_bit_count <= half_bit_count_next;
        active         <= active_next;
        frame_open     <= frame_open_next;
        close_after    <= close_after_next;
        clock_pin      <= clock_pin_next;
        data_pin       <= data_pin_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // a new mode moves an idle clock to its new idle level at once;
      // mid-byte it only takes effect at the next tick
      if (xfer_mode_we) begin
        xfer_mode <= xfer_mode_wdata;
        if (!active && !exec) begin
          clock_pin <= xfer_mode_wdata[MODE_CPOL_BIT];
        end
      end
    end
  end

  // output item register, loaded on every executed item
  always_ff @(posedge clk) begin
    if (exec) begin
      sck_level  <= clock_pin_next;
      mosi_level <= data_pin_next;
      cs_n       <= ~frame_open_next;
      busy_res   <= active_next;
      rx_valid   <= valid_next;
      rx_byte    <= rx_shift_next;
    end
  end

  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |-> !busy_res)
    else $error("completed byte reported while still busy");

  a_busy_selects : assert property (@(posedge clk) disable iff (rst)
    out_valid && busy_res |-> !cs_n)
    else $error("byte shifted with chip select released");

  a_last_tick_ends : assert property (@(posedge clk) disable iff (rst)
    exec && (q_out.item.kind == KIND_TICK) && active && last_half |=> !active)
    else $error("byte did not end after the last half-bit tick");

endmodule : sms_back

`default_nettype wire

// File: design/spi_master_byte_shifter.sv
// ----------------------------------------------------------------------------
// spi_master_byte_shifter - SPI master, one byte MSB first, modes 0 to 3
// Front queue decodes load and tick items; back engine drives the pins.
// ----------------------------------------------------------------------------
// Items wait in the two-entry queue; results are held in the output register.
// Throughput: one item per clock unless stalled; every load or half-bit tick
//   is a single register update in the back engine, and a two-entry queue
//   plus the output register let both sides stall on their own.
// Reset (rst, synchronous): mode 1, clock and data pin state low, frame closed,
//   idle, queue and output empty; the result item fields are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_master_byte_shifter import sms_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // input items
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     cmd,
  input  wire logic [BITS_PER_WORD-1:0] tx_byte,
  input  wire logic                     end_frame,
  input  wire logic                     miso_level,
  // mode register write
  input  wire logic                     xfer_mode_we,
  input  wire logic [MODE_W-1:0]        xfer_mode_wdata,
  // result items
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          sck_level,
  output logic                          mosi_level,
  output logic                          cs_n,
  output logic                          busy_res,
  output logic                          rx_valid,
  output logic [BITS_PER_WORD-1:0]      rx_byte
);

  // queued item towards the engine, and the engine's pull
  sms_queue_out_t q_out;
  logic           q_ready;

  // Front: decode the command and buffer up to two items
  sms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .tx_byte    (tx_byte),
    .end_frame  (end_frame),
    .miso_level (miso_level),
    .q_out      (q_out),
    .q_ready    (q_ready)
  );

  // Back: advance the shift state one item per cycle unless the held result item is not yet taken, and hold the result
  // item until it is taken; the mode register lives here as well
  sms_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_out           (q_out),
    .q_ready         (q_ready),
    .xfer_mode_we    (xfer_mode_we),
    .xfer_mode_wdata (xfer_mode_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sck_level       (sck_level),
    .mosi_level      (mosi_level),
    .cs_n            (cs_n),
    .busy_res        (busy_res),
    .rx_valid        (rx_valid),
    .rx_byte         (rx_byte)
  );

endmodule : spi_master_byte_shifter

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of the SPI master byte shifter
// Offers load and half-bit tick items in all four SPI modes, with random
// gaps on both sides and one long receiver hold-off. Predicts every step's
// pins and received byte, and checks each result item against it.
// ----------------------------------------------------------------------------

module tb;
  import sms_pkg::*;

  localparam int MAX_CYCLES      = 200000;
  localparam int DRAIN_PAUSE     = 4;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int GAP_PERCENT     = 31;
  localparam int MAX_REPORTS     = 20;

  // Pin levels and receive register after one step
  typedef struct {
    logic                     sck;
    logic                     mosi;
    logic                     cs_n;
    logic                     busy;
    logic                     rx_valid;
    logic [BITS_PER_WORD-1:0] rx;
  } pin_state_t;

  // --------------------------------------------------------------------------
  // Pin tracker: follows the shifter step by step and holds the pin states
  // that are still due on the output channel.
  // --------------------------------------------------------------------------
  class spi_pin_tracker;
    logic [MODE_W-1:0]        mode;
    logic [BITS_PER_WORD-1:0] tx_sr;
    logic [BITS_PER_WORD-1:0] rx_sr;
    int                       half_cnt;
    bit                       active;
    bit                       frame_open;
    bit                       close_after;
    logic                     sck;
    logic                     mosi;
    pin_state_t               pins_due[$];
    int mismatches, checked, bytes_done, frames_closed;
    int loads_ignored, ticks_ignored, busy_mode_writes;

    function new();
      mode        = XFER_MODE_RESET;
      tx_sr       = '0;
      rx_sr       = '0;
      half_cnt    = 0;
      active      = 1'b0;
      frame_open  = 1'b0;
      close_after = 1'b0;
      sck         = 1'b0;
      mosi        = 1'b0;
    endfunction

    function void shift_out();
      mosi  = tx_sr[BITS_PER_WORD-1];
      tx_sr = tx_sr << 1;
    endfunction

    function void shift_in(logic miso);
      rx_sr = {rx_sr[BITS_PER_WORD-2:0], miso};
    endfunction

    // A new mode moves an idle clock at once; mid-byte it waits for the next tick
    function void write_mode(logic [MODE_W-1:0] m);
      mode = m;
      if (active) busy_mode_writes++;
      else sck = m[MODE_CPOL_BIT];
    endfunction

    function void take_item(item_kind_t kind, logic [BITS_PER_WORD-1:0] tx,
                            logic endf, logic miso);
      logic       cpol;
      logic       cpha;
      logic       done;
      pin_state_t p;
      cpol = mode[MODE_CPOL_BIT];
      cpha = mode[MODE_CPHA_BIT];
      done = 1'b0;
      if (kind == KIND_LOAD) begin
        if (active) begin
          loads_ignored++;
        end else begin
          tx_sr       = tx;
          rx_sr       = '0;
          half_cnt    = 0;
          active      = 1'b1;
          frame_open  = 1'b1;
          close_after = endf;
          sck         = cpol;
          if (!cpha) shift_out();
        end
      end else if (!active) begin
        ticks_ignored++;
      end else begin
        if (half_cnt % 2 == 0) begin
          sck = ~cpol;
          if (cpha) shift_out();
          else shift_in(miso);
        end else begin
          sck = cpol;
          if (cpha) shift_in(miso);
          else if (half_cnt + 1 < HALF_BITS) shift_out();
        end
        half_cnt++;
        if (half_cnt >= HALF_BITS) begin
          half_cnt = 0;
          active   = 1'b0;
          done     = 1'b1;
          bytes_done++;
          if (close_after) begin
            frame_open  = 1'b0;
            close_after = 1'b0;
            frames_closed++;
          end
        end
      end
      p.sck      = sck;
      p.mosi     = mosi;
      p.cs_n     = ~frame_open;
      p.busy     = active;
      p.rx_valid = done;
      p.rx       = rx_sr;
      pins_due.push_back(p);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("tb: mismatch at %0t ns: %s", $time, what);
    endtask

    task check_field(string name, logic [BITS_PER_WORD-1:0] got,
                     logic [BITS_PER_WORD-1:0] want);
      if (got !== want)
        report($sformatf("%s is %0h, expected %0h (result %0d)", name, got, want, checked));
    endtask

    task check_pins(logic s, logic m, logic c, logic b, logic v,
                    logic [BITS_PER_WORD-1:0] rx);
      pin_state_t p;
      if (pins_due.size() == 0) begin
        report("result item with no input item waiting");
        return;
      end
      p = pins_due.pop_front();
      checked++;
      check_field("sck_level", BITS_PER_WORD'(s), BITS_PER_WORD'(p.sck));
      check_field("mosi_level", BITS_PER_WORD'(m), BITS_PER_WORD'(p.mosi));
      check_field("cs_n", BITS_PER_WORD'(c), BITS_PER_WORD'(p.cs_n));
      check_field("busy_res", BITS_PER_WORD'(b), BITS_PER_WORD'(p.busy));
      check_field("rx_valid", BITS_PER_WORD'(v), BITS_PER_WORD'(p.rx_valid));
      check_field("rx_byte", rx, p.rx);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     cmd;
  logic [BITS_PER_WORD-1:0] tx_byte;
  logic                     end_frame;
  logic                     miso_level;
  logic                     xfer_mode_we;
  logic [MODE_W-1:0]        xfer_mode_wdata;
  logic                     out_valid;
  logic                     out_ready;
  logic                     sck_level;
  logic                     mosi_level;
  logic                     cs_n;
  logic                     busy_res;
  logic                     rx_valid;
  logic [BITS_PER_WORD-1:0] rx_byte;

  spi_pin_tracker tracker = new();

  // Idling switches for both sides, and a counter of requested hold-offs
  bit tx_gaps   = 1'b1;
  bit rx_gaps   = 1'b1;
  int hold_asks = 0;
  int cycle     = 0;

  always #4 clk = ~clk;

  spi_master_byte_shifter uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .tx_byte        (tx_byte),
    .end_frame      (end_frame),
    .miso_level     (miso_level),
    .xfer_mode_we   (xfer_mode_we),
    .xfer_mode_wdata(xfer_mode_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sck_level      (sck_level),
    .mosi_level     (mosi_level),
    .cs_n           (cs_n),
    .busy_res       (busy_res),
    .rx_valid       (rx_valid),
    .rx_byte        (rx_byte)
  );

  // Sample both handshakes at the edge, with the levels that stood before it.
  // Note the input item first, so a result can never overtake its own item.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        tracker.take_item(item_kind_t'(cmd), tx_byte, end_frame, miso_level);
      if (out_valid && out_ready)
        tracker.check_pins(sck_level, mosi_level, cs_n, busy_res, rx_valid, rx_byte);
    end
  end

  // Watchdog: drop the run if it stalls far beyond the slowest correct run
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, or none at all, and a long hold-off on request
  // while the sender keeps offering items, so the block fills and backs up.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gaps) begin
        out_ready <= ($urandom_range(99) >= GAP_PERCENT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one item, after a random gap, and hold it until it is taken
  task automatic send_item(item_kind_t kind, logic [BITS_PER_WORD-1:0] tx,
                           logic endf, logic miso);
    while (tx_gaps && $urandom_range(99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= kind;
    tx_byte    <= tx;
    end_frame  <= endf;
    miso_level <= miso;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Fields unused by the item kind carry random values
  task automatic send_tick(logic miso);
    send_item(KIND_TICK, BITS_PER_WORD'($urandom), 1'($urandom), miso);
  endtask

  task automatic send_load(logic [BITS_PER_WORD-1:0] tx, logic endf);
    send_item(KIND_LOAD, tx, endf, 1'($urandom));
  endtask

  // Drop valid, let the last accepted item reach the tracker, wait until
  // every result has come back, then let the block settle for its latency
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pins_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic set_mode(logic [MODE_W-1:0] m);
    settle_idle();
    xfer_mode_we    <= 1'b1;
    xfer_mode_wdata <= m;
    @(posedge clk);
    tracker.write_mode(m);
    xfer_mode_we <= 1'b0;
  endtask

  // Mostly whole bytes (load plus sixteen ticks) with random data and frame
  // ends; the rest is noise: loads while busy, cut-short bytes, stray ticks.
  task automatic run_traffic(int quota);
    int sent;
    int ticks;
    int r;
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_load(BITS_PER_WORD'($urandom), $urandom_range(99) < 35);
        for (int i = 0; i < HALF_BITS; i++) begin
          if ($urandom_range(99) < 4) begin
            send_load(BITS_PER_WORD'($urandom), 1'($urandom));
            sent++;
          end
          send_tick(1'($urandom));
        end
        sent += HALF_BITS + 1;
      end else if (r < 90) begin
        // Cut the byte short; a following load is ignored until later ticks finish the byte
        ticks = $urandom_range(HALF_BITS - 1, 1);
        send_load(BITS_PER_WORD'($urandom), 1'($urandom));
        repeat (ticks) send_tick(1'($urandom));
        sent += ticks + 1;
      end else begin
        ticks = $urandom_range(3, 1);
        repeat (ticks) send_tick(1'($urandom));
        sent += ticks;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int mode_plan [8];
    mode_plan       = '{0, 3, 2, 1, 3, 0, 2, 1};
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    cmd             <= CMD_TICK;
    tx_byte         <= '0;
    end_frame       <= 1'b0;
    miso_level      <= 1'b0;
    xfer_mode_we    <= 1'b0;
    xfer_mode_wdata <= XFER_MODE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part in the reset mode: tick while idle, an all-ones byte with
    // a load while busy in its way, then an all-zeros byte that closes the frame.
    send_tick(1'b1);
    send_load(8'hFF, 1'b0);
    send_load(8'h00, 1'b1);
    repeat (HALF_BITS) send_tick(1'b1);
    send_load(8'h00, 1'b1);
    // Stop part way through the byte, so the first mode write lands mid-byte
    repeat (5) send_tick(1'b0);

    // Random phases across all modes, extremes first. Phase 1 holds off the
    // receiver for a long stretch; phase 4 runs with no idling on either side.
    for (int p = 0; p < 8; p++) begin
      tx_gaps = (p != 4);
      rx_gaps = (p != 4);
      set_mode(MODE_W'(mode_plan[p]));
      if (p == 1) hold_asks++;
      run_traffic(ITEMS_PER_PHASE);
    end

    settle_idle();
    repeat (DRAIN_PAUSE) @(posedge clk);

    $display("tb: %0d result items checked; %0d bytes shifted, %0d frames closed",
             tracker.checked, tracker.bytes_done, tracker.frames_closed);
    $display("tb: %0d loads while busy, %0d ticks while idle, %0d mode writes mid-byte",
             tracker.loads_ignored, tracker.ticks_ignored, tracker.busy_mode_writes);
    if (tracker.mismatches == 0 && tracker.pins_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
